// ----- rtl/core/query_string_percent_decoder_macros.svh -----
// Assertion macros shared by the query string percent decoder.
`ifndef QUERY_STRING_PERCENT_DECODER_MACROS_SVH
`define QUERY_STRING_PERCENT_DECODER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define QSPD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qspd: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define QSPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qspd: next-cycle check failed");

`endif

// ----- rtl/core/qspd_pkg.sv -----
// Types and constants of the query string percent decoder.
package qspd_pkg;

   // Result word kinds.
   typedef enum logic [2:0] {
      KIND_KEY        = 3'd0,
      KIND_VALUE      = 3'd1,
      KIND_PAIR_END   = 3'd2,
      KIND_STRING_END = 3'd3,
      KIND_ERROR      = 3'd4
   } kind_type;

   // Control register indexes.
   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PLUS_AS_SPACE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPLIT_PAIRS   = 1'b1;

   // Characters with a special meaning in a query string.
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   // One result word.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] out_byte;
      logic       last_of_run;
   } item_type;

   // Hex digit decode: bit 4 is set when the byte is not a hex digit.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [7:0] diff;
      logic [4:0] res;
      diff = 8'h00;
      res  = 5'h10;
      if (b inside {[8'h30:8'h39]}) begin
         diff = b - 8'h30;
         res  = {1'b0, diff[3:0]};
      end else if (b inside {[8'h61:8'h66]}) begin
         diff = b - 8'h57;
         res  = {1'b0, diff[3:0]};
      end else if (b inside {[8'h41:8'h46]}) begin
         diff = b - 8'h37;
         res  = {1'b0, diff[3:0]};
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/qspd_if.sv -----
// Channel interfaces of the query string percent decoder.

// Input byte channel.
interface qspd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       end_of_string;
   modport source (output valid, output in_byte, output end_of_string, input ready);
   modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

// Result word channel.
interface qspd_rsp_if;
   logic                valid;
   logic                ready;
   qspd_pkg::kind_type  kind;
   logic [7:0]          out_byte;
   logic                last_of_run;
   modport source (output valid, output kind, output out_byte, output last_of_run,
                   input ready);
   modport sink (input valid, input kind, input out_byte, input last_of_run,
                 output ready);
endinterface

// Control register write channel.
interface qspd_csr_if;
   logic                              valid;
   logic                              ready;
   logic [qspd_pkg::CSR_INDEX_W-1:0]  index;
   logic                              data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/query_string_percent_decoder.sv -----
// Streaming query string splitter and percent decoder, top level.
//
// The block takes one byte of a query string per word on req_chan, with
// end_of_string on the final byte, and returns key bytes, value bytes, pair
// ends, a string end or a string error on rsp_chan. It sustains one byte per
// clock cycle while rsp_chan is ready: a byte passes an input register, is
// decoded combinationally into up to three result words held in a three-entry
// result buffer, and leaves from the head of that buffer. The buffer drains
// one word per cycle while rsp_chan is ready, so a byte that makes two or
// three words (the final byte of a string) holds back the next byte. Registers
// plus_as_space and split_pairs are written through csr_chan, which is always
// ready, and should only be changed between strings while the block is idle.
`include "query_string_percent_decoder_macros.svh"

module query_string_percent_decoder (
   input logic        clock,
   input logic        reset,
   qspd_req_if.sink   req_chan,
   qspd_rsp_if.source rsp_chan,
   qspd_csr_if.sink   csr_chan
);
   import qspd_pkg::*;

   // Position inside a percent escape.
   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } esc_type;

   // Control registers.
   logic plus_as_space_ff;
   logic split_pairs_ff;

   // Input register.
   logic       s1_valid_ff;
   logic [7:0] s1_byte_ff;
   logic       s1_eos_ff;

   // Per-string decoder state.
   esc_type    esc_ff, esc_in;
   logic [3:0] hi_ff, hi_in;
   logic       in_value_ff, in_value_in;
   logic       pair_started_ff, pair_started_in;
   logic       error_ff, error_in;

   // Result buffer.
   item_type   rbuf_ff [3];
   item_type   slot_in [3];
   logic [1:0] cnt_ff, cnt_in;

   // Decode intermediates.
   logic [4:0] dig;
   logic       data_hit;
   kind_type   data_kind;
   logic [7:0] data_val;
   logic       amp_end;
   logic       take_c0, take_c1;
   logic [1:0] slot_cnt;
   logic       pop, load;

   // Register writes.
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         plus_as_space_ff <= 1'b1;
         split_pairs_ff   <= 1'b1;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_PLUS_AS_SPACE: plus_as_space_ff <= csr_chan.data;
            CSR_SPLIT_PAIRS:   split_pairs_ff   <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // Handshake: the buffer takes a decoded byte when empty or emptying now.
   assign pop  = (cnt_ff != 2'd0) && rsp_chan.ready;
   assign load = s1_valid_ff && ((cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && pop));
   assign req_chan.ready = !s1_valid_ff || load;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         s1_byte_ff <= req_chan.in_byte;
         s1_eos_ff  <= req_chan.end_of_string;
      end
   end

   // Decode one byte: next state and its result words.
   always_comb begin
      esc_in          = esc_ff;
      hi_in           = hi_ff;
      in_value_in     = in_value_ff;
      pair_started_in = pair_started_ff;
      error_in        = error_ff;
      dig             = hex_digit(s1_byte_ff);
      data_hit        = 1'b0;
      data_val        = s1_byte_ff;
      amp_end         = 1'b0;
      data_kind       = (split_pairs_ff && in_value_ff) ? KIND_VALUE : KIND_KEY;

      if (!error_ff) begin
         if (esc_ff != ESC_NONE) begin
            if (dig[4]) begin
               error_in = 1'b1;
               esc_in   = ESC_NONE;
            end else if (esc_ff == ESC_HIGH) begin
               hi_in  = dig[3:0];
               esc_in = ESC_LOW;
            end else begin
               data_hit = 1'b1;
               data_val = {hi_ff, dig[3:0]};
               esc_in   = ESC_NONE;
               hi_in    = 4'h0;
            end
         end else if (split_pairs_ff && (s1_byte_ff == CHAR_AMP)) begin
            amp_end         = pair_started_ff;
            pair_started_in = 1'b0;
            in_value_in     = 1'b0;
         end else begin
            if (split_pairs_ff) begin
               pair_started_in = 1'b1;
            end
            if (split_pairs_ff && (s1_byte_ff == CHAR_EQUALS) && !in_value_ff) begin
               in_value_in = 1'b1;
            end else if (s1_byte_ff == CHAR_PERCENT) begin
               esc_in = ESC_HIGH;
            end else if (plus_as_space_ff && (s1_byte_ff == CHAR_PLUS)) begin
               data_hit = 1'b1;
               data_val = CHAR_SPACE;
            end else begin
               data_hit = 1'b1;
            end
         end
      end

      // An escape left open at the final byte is an error too.
      if (s1_eos_ff && (esc_in != ESC_NONE)) begin
         error_in = 1'b1;
      end

      // Pack the words in order; an error at string end replaces them all.
      take_c0  = (data_hit || amp_end) && !(s1_eos_ff && error_in);
      take_c1  = s1_eos_ff && !error_in && pair_started_in;
      slot_cnt = 2'd0;
      for (int i = 0; i < 3; i++) begin
         slot_in[i] = '{kind: KIND_KEY, out_byte: 8'h00, last_of_run: 1'b0};
      end
      if (take_c0) begin
         slot_in[0] = amp_end
            ? item_type'{kind: KIND_PAIR_END, out_byte: 8'h00, last_of_run: 1'b0}
            : item_type'{kind: data_kind, out_byte: data_val, last_of_run: 1'b0};
         slot_cnt = 2'd1;
      end
      if (take_c1) begin
         slot_in[slot_cnt] = '{kind: KIND_PAIR_END, out_byte: 8'h00, last_of_run: 1'b0};
         slot_cnt = slot_cnt + 2'd1;
      end
      if (s1_eos_ff) begin
         slot_in[slot_cnt] = '{kind: error_in ? KIND_ERROR : KIND_STRING_END,
                               out_byte: 8'h00, last_of_run: 1'b0};
         slot_cnt = slot_cnt + 2'd1;
      end
      for (int i = 0; i < 3; i++) begin
         slot_in[i].last_of_run = (2'(i + 1) == slot_cnt);
      end

      // The final byte returns all string state to its start.
      if (s1_eos_ff) begin
         esc_in          = ESC_NONE;
         hi_in           = 4'h0;
         in_value_in     = 1'b0;
         pair_started_in = 1'b0;
         error_in        = 1'b0;
      end
   end

   // String state advances as each byte enters the result buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         esc_ff          <= ESC_NONE;
         hi_ff           <= 4'h0;
         in_value_ff     <= 1'b0;
         pair_started_ff <= 1'b0;
         error_ff        <= 1'b0;
      end else if (load) begin
         esc_ff          <= esc_in;
         hi_ff           <= hi_in;
         in_value_ff     <= in_value_in;
         pair_started_ff <= pair_started_in;
         error_ff        <= error_in;
      end
   end

   // Result buffer fill count.
   always_comb begin
      cnt_in = cnt_ff;
      if (load) begin
         cnt_in = slot_cnt;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // Result buffer contents shift toward the head as words leave.
   always_ff @(posedge clock) begin
      if (load) begin
         rbuf_ff <= slot_in;
      end else if (pop) begin
         rbuf_ff[0] <= rbuf_ff[1];
         rbuf_ff[1] <= rbuf_ff[2];
      end
   end

   assign rsp_chan.valid       = (cnt_ff != 2'd0);
   assign rsp_chan.kind        = rbuf_ff[0].kind;
   assign rsp_chan.out_byte    = rbuf_ff[0].out_byte;
   assign rsp_chan.last_of_run = rbuf_ff[0].last_of_run;

   // The head word ends its byte's run exactly when it is the last one held.
   `QSPD_ASSERT_SAME(a_last_matches_count, clock, reset,
      rsp_chan.valid, rsp_chan.last_of_run == (cnt_ff == 2'd1))
   // A final byte leaves all string state cleared.
   `QSPD_ASSERT_NEXT(a_eos_clears_state, clock, reset, load && s1_eos_ff,
      esc_ff == ESC_NONE && !error_ff && !in_value_ff && !pair_started_ff)
   // A byte waiting in the input register stays there until the buffer takes it.
   `QSPD_ASSERT_NEXT(a_input_held, clock, reset, s1_valid_ff && !load,
      s1_valid_ff && $stable(s1_byte_ff) && $stable(s1_eos_ff))

endmodule

// ----- tb/query_string_percent_decoder_tb.sv -----
// Testbench for the query string percent decoder: random strings checked by a scoreboard.
`timescale 1ns / 1ps

// Progress through a percent escape.
typedef enum logic [1:0] {
   ESC_IDLE,
   ESC_HIGH_DIGIT,
   ESC_LOW_DIGIT
} escape_step_type;

// Result side stall behavior.
typedef enum logic [1:0] {
   RX_OPEN,
   RX_RANDOM,
   RX_PERIODIC,
   RX_BURSTY
} stall_mode_type;

// Keeps its own copy of the decoder state and the words each byte should produce.
class decoder_scoreboard;
   logic                plus_as_space;
   logic                split_pairs;
   escape_step_type     escape_step;
   logic [3:0]          high_digit;
   logic                in_value;
   logic                pair_open;
   logic                bad_escape;
   qspd_pkg::item_type  run_words[$];
   qspd_pkg::item_type  decoded_words[$];
   int unsigned         failures;

   function new();
      plus_as_space = 1'b1;
      split_pairs   = 1'b1;
      failures      = 0;
      clear_string();
   endfunction

   function void clear_string();
      escape_step = ESC_IDLE;
      high_digit  = 4'h0;
      in_value    = 1'b0;
      pair_open   = 1'b0;
      bad_escape  = 1'b0;
   endfunction

   function void set_register(logic [qspd_pkg::CSR_INDEX_W-1:0] index, logic data);
      if (index == qspd_pkg::CSR_PLUS_AS_SPACE) begin
         plus_as_space = data;
      end else if (index == qspd_pkg::CSR_SPLIT_PAIRS) begin
         split_pairs = data;
      end
   endfunction

   // Value of a hex digit in either case, or -1 for any other byte.
   function int digit_value(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
      return -1;
   endfunction

   function void add_word(qspd_pkg::kind_type kind, logic [7:0] value);
      qspd_pkg::item_type w;
      w.kind        = kind;
      w.out_byte    = value;
      w.last_of_run = 1'b0;
      run_words.insert(run_words.size(), w);
   endfunction

   // Decodes one accepted byte and queues the words it produces.
   function void decode_byte(logic [7:0] b, logic eos);
      qspd_pkg::kind_type data_kind;
      int                 digit;
      data_kind = (split_pairs && in_value) ? qspd_pkg::KIND_VALUE : qspd_pkg::KIND_KEY;
      run_words.delete();

      if (!bad_escape) begin
         if (escape_step != ESC_IDLE) begin
            // Inside an escape every byte must be a hex digit.
            digit = digit_value(b);
            if (digit < 0) begin
               bad_escape  = 1'b1;
               escape_step = ESC_IDLE;
            end else if (escape_step == ESC_HIGH_DIGIT) begin
               high_digit  = digit[3:0];
               escape_step = ESC_LOW_DIGIT;
            end else begin
               add_word(data_kind, {high_digit, digit[3:0]});
               escape_step = ESC_IDLE;
               high_digit  = 4'h0;
            end
         end else if (split_pairs && b == qspd_pkg::CHAR_AMP) begin
            // An empty pair closes silently.
            if (pair_open) add_word(qspd_pkg::KIND_PAIR_END, 8'h00);
            pair_open = 1'b0;
            in_value  = 1'b0;
         end else begin
            if (split_pairs) pair_open = 1'b1;
            if (split_pairs && b == qspd_pkg::CHAR_EQUALS && !in_value) begin
               in_value = 1'b1;
            end else if (b == qspd_pkg::CHAR_PERCENT) begin
               escape_step = ESC_HIGH_DIGIT;
            end else if (plus_as_space && b == qspd_pkg::CHAR_PLUS) begin
               add_word(data_kind, qspd_pkg::CHAR_SPACE);
            end else begin
               add_word(data_kind, b);
            end
         end
      end

      // The final byte closes the string, or reports its error alone.
      if (eos) begin
         if (escape_step != ESC_IDLE) bad_escape = 1'b1;
         if (bad_escape) begin
            run_words.delete();
            add_word(qspd_pkg::KIND_ERROR, 8'h00);
         end else begin
            if (pair_open) add_word(qspd_pkg::KIND_PAIR_END, 8'h00);
            add_word(qspd_pkg::KIND_STRING_END, 8'h00);
         end
         clear_string();
      end

      if (run_words.size() > 0) run_words[run_words.size()-1].last_of_run = 1'b1;
      foreach (run_words[i]) decoded_words.insert(decoded_words.size(), run_words[i]);
   endfunction

   // Compares one accepted result word with the oldest expected word.
   function void check_word(qspd_pkg::kind_type kind, logic [7:0] value, logic last);
      qspd_pkg::item_type w;
      if (decoded_words.size() == 0) begin
         $display("%0t: unexpected word, expected none, actual kind %0d byte 0x%02h last %0b",
                  $time, kind, value, last);
         failures++;
         return;
      end
      w = decoded_words.pop_front();
      if (kind !== w.kind) begin
         $display("%0t: kind expected %0d actual %0d", $time, w.kind, kind);
         failures++;
      end
      if (value !== w.out_byte) begin
         $display("%0t: out_byte expected 0x%02h actual 0x%02h", $time, w.out_byte, value);
         failures++;
      end
      if (last !== w.last_of_run) begin
         $display("%0t: last_of_run expected %0b actual %0b", $time, w.last_of_run, last);
         failures++;
      end
   endfunction

   function int unsigned pending();
      return decoded_words.size();
   endfunction
endclass

module query_string_percent_decoder_tb;
   import qspd_pkg::*;

   localparam int unsigned PHASE_BYTES = 44;
   localparam int unsigned PHASES      = 8;

   logic clock;
   logic reset;

   qspd_req_if req_bus ();
   qspd_rsp_if rsp_bus ();
   qspd_csr_if csr_bus ();

   decoder_scoreboard sb = new();

   logic [7:0]  text[$];
   int unsigned burst_left;
   int unsigned sent_bytes;

   query_string_percent_decoder i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // Clock generation.
   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // The run is cut off if it hangs.
   initial begin
      #5_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Sends one byte in bursts, with random gaps after a burst ends.
   task automatic send_byte(input logic [7:0] b, input logic eos);
      int unsigned gap;
      @(negedge clock);
      req_bus.valid         = 1'b1;
      req_bus.in_byte       = b;
      req_bus.end_of_string = eos;
      do @(posedge clock); while (!req_bus.ready);
      sb.decode_byte(b, eos);
      sent_bytes++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 24);
         repeat (gap) begin
            @(negedge clock);
            req_bus.valid         = 1'b0;
            req_bus.in_byte       = 8'($urandom_range(0, 255));
            req_bus.end_of_string = 1'($urandom_range(0, 1));
         end
      end
   endtask

   task automatic send_text();
      foreach (text[i]) send_byte(text[i], i == text.size() - 1);
   endtask

   // Lowers valid and waits for every expected word, then for the pipeline to settle.
   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input logic data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = index;
      csr_bus.data  = data;
      do @(posedge clock); while (!csr_bus.ready);
      sb.set_register(index, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Appends one byte to the string being built.
   function automatic void append_char(logic [7:0] c);
      text.insert(text.size(), c);
   endfunction

   // A hex digit character in random case.
   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 10) return 8'h30 + 8'(n);
      return (($urandom_range(0, 1) != 0) ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] plain_char();
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range('h61, 'h7a));
         1:       return 8'($urandom_range('h41, 'h5a));
         default: return 8'($urandom_range('h30, 'h39));
      endcase
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (sb.digit_value(c) >= 0);
      return c;
   endfunction

   function automatic void push_escape(logic [7:0] value);
      append_char(CHAR_PERCENT);
      append_char(hex_char(value[7:4]));
      append_char(hex_char(value[3:0]));
   endfunction

   // One piece of key or value content.
   function automatic void push_token();
      int unsigned pick;
      logic [7:0]  delims[4];
      delims = '{CHAR_AMP, CHAR_EQUALS, CHAR_PLUS, CHAR_PERCENT};
      pick   = $urandom_range(0, 99);
      if (pick < 55)      append_char(plain_char());
      else if (pick < 67) append_char(CHAR_PLUS);
      else if (pick < 80) push_escape(8'($urandom_range(0, 255)));
      else if (pick < 90) push_escape(delims[$urandom_range(0, 3)]);
      else if (pick < 95) append_char(CHAR_EQUALS);
      else                append_char(8'($urandom_range(0, 255)));
   endfunction

   // A query string with random pairs and delimiters; a raw random byte may spoil it.
   function automatic void make_query();
      int unsigned pairs;
      text.delete();
      pairs = $urandom_range(1, 4);
      if ($urandom_range(0, 9) == 0) append_char(CHAR_AMP);
      for (int p = 0; p < pairs; p++) begin
         if (p > 0) begin
            append_char(CHAR_AMP);
            if ($urandom_range(0, 9) == 0) append_char(CHAR_AMP);
         end
         repeat ($urandom_range(0, 4)) push_token();
         if ($urandom_range(0, 99) < 85) begin
            append_char(CHAR_EQUALS);
            repeat ($urandom_range(0, 5)) push_token();
         end
      end
      if ($urandom_range(0, 9) == 0) append_char(CHAR_AMP);
      if (text.size() == 0) append_char(plain_char());
   endfunction

   // A well formed string spoiled by a bad or cut-off escape.
   function automatic void make_broken_query();
      int unsigned at;
      make_query();
      case ($urandom_range(0, 2))
         0: begin
            at = $urandom_range(0, text.size());
            text.insert(at, non_hex_char());
            text.insert(at, CHAR_PERCENT);
         end
         1: begin
            at = $urandom_range(0, text.size());
            text.insert(at, non_hex_char());
            text.insert(at, hex_char(4'($urandom_range(0, 15))));
            text.insert(at, CHAR_PERCENT);
         end
         default: begin
            append_char(CHAR_PERCENT);
            if ($urandom_range(0, 1) != 0) append_char(hex_char(4'($urandom_range(0, 15))));
         end
      endcase
   endfunction

   // Raw bytes salted with delimiters.
   function automatic void make_noise();
      logic [7:0] specials[5];
      specials = '{CHAR_AMP, CHAR_EQUALS, CHAR_PLUS, CHAR_PERCENT, CHAR_SPACE};
      text.delete();
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(0, 3) == 0) append_char(specials[$urandom_range(0, 4)]);
         else                           append_char(8'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void load_text(string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) append_char(s[i]);
   endfunction

   // Result side: checks at the rising edge and stalls on its own pattern.
   initial begin : receiver
      stall_mode_type mode;
      int unsigned    mode_left;
      int unsigned    stall_left;
      int unsigned    open_left;
      int unsigned    tick;
      mode          = RX_OPEN;
      mode_left     = 0;
      stall_left    = 0;
      open_left     = 0;
      tick          = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_word(rsp_bus.kind, rsp_bus.out_byte, rsp_bus.last_of_run);
         end
         @(negedge clock);
         tick++;
         if (mode_left == 0) begin
            mode      = stall_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 96);
         end
         mode_left--;
         case (mode)
            RX_OPEN:     rsp_bus.ready = 1'b1;
            RX_RANDOM:   rsp_bus.ready = ($urandom_range(0, 3) != 0);
            RX_PERIODIC: rsp_bus.ready = (tick % 4 != 3);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_bus.ready = 1'b0;
               end else if (open_left > 0) begin
                  open_left--;
                  rsp_bus.ready = 1'b1;
               end else begin
                  stall_left    = $urandom_range(1, 12);
                  open_left     = $urandom_range(1, 6);
                  rsp_bus.ready = 1'b0;
               end
            end
         endcase
      end
   end

   // Main sequence: reset, directed strings, then random phases under each setting.
   initial begin : stimulus
      logic [1:0]  setting;
      int unsigned pick;
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.in_byte       = 8'h00;
      req_bus.end_of_string = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.index         = CSR_PLUS_AS_SPACE;
      csr_bus.data          = 1'b0;
      burst_left            = 0;
      sent_bytes            = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Leading, trailing and double ampersand, plus in a key, escaped plus, later
      // equals, a pair that is only an equals sign and a pair with no equals sign.
      load_text("&a+=%2B=&&=&k&");
      send_text();
      // Mixed case escape of 0xFF, then an escape cut off at the final byte.
      load_text("%fF%0");
      send_text();
      // A delimiter where a hex digit belongs, with the rest swallowed.
      load_text("%&=");
      send_text();
      // Raw extreme bytes as single byte strings.
      text.delete();
      append_char(8'h00);
      send_text();
      text.delete();
      append_char(8'hFF);
      send_text();
      wait_drained();

      // Random phases over every register setting.
      for (int phase = 0; phase < PHASES; phase++) begin
         setting = 2'(phase + 1);
         write_register(CSR_PLUS_AS_SPACE, setting[0]);
         write_register(CSR_SPLIT_PAIRS, setting[1]);
         sent_bytes = 0;
         while (sent_bytes < PHASE_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 70)      make_query();
            else if (pick < 85) make_broken_query();
            else                make_noise();
            send_text();
         end
         wait_drained();
      end

      if (sb.failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
